/* design/cte_pkg.sv */
// Package for the cube texel to equirectangular address block.
// Holds payload types, pipeline constants, the arctangent table and the stage function.
// No dependencies.
`default_nettype none

package cte_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int MAX_FACE_SIZE = 1024;
   localparam int MAX_SRC_DIM   = 4096;
   localparam int PRE_SHIFT     = 16;
   localparam int DROP          = 32 - ANGLE_BITS;
   localparam int AW            = ANGLE_BITS + 2;   // signed angle width
   localparam int VW            = 32;               // CORDIC vector width
   localparam int SQRT_STEPS    = 27;
   localparam int ROOT_W        = 27;
   localparam int REM_W         = 30;
   localparam int N_W           = 21;

   // pipeline stage map
   localparam int ST_VEC  = 1;
   localparam int ST_PREP = 2;
   localparam int ST_SQRT = 3;
   localparam int ST_LATP = ST_SQRT + SQRT_STEPS;
   localparam int ST_LAT  = ST_LATP + 1;
   localparam int ST_UV   = ST_LAT + ANGLE_BITS;
   localparam int ST_MUL  = ST_UV + 1;
   localparam int ST_FIX  = ST_MUL + 1;
   localparam int ST_IDX  = ST_FIX + 1;
   localparam int NSTAGE  = ST_IDX + 1;

   // register indexes
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FACE_SIZE  = 2'd2;

   // face codes
   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_NX = 3'd1;
   localparam logic [2:0] FACE_PY = 3'd2;
   localparam logic [2:0] FACE_NY = 3'd3;
   localparam logic [2:0] FACE_PZ = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   typedef struct packed {
      logic [2:0] face;
      logic [9:0] tex_x;
      logic [9:0] tex_y;
   } req_type;

   typedef struct packed {
      logic [11:0] src_col;
      logic [11:0] src_row;
      logic [23:0] src_index;
      logic        bad_coord;
   } rsp_type;

   typedef struct packed {
      logic [2:0]             face;
      logic [9:0]             tx;
      logic [9:0]             ty;
      logic                   bad;
      logic signed [12:0]     dx;
      logic signed [12:0]     dy;
      logic signed [12:0]     dz;
      logic [N_W-1:0]         n;
      logic                   zlon;
      logic signed [VW-1:0]   lx;
      logic signed [VW-1:0]   ly;
      logic signed [AW-1:0]   lang;
      logic [REM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic signed [VW-1:0]   qx;
      logic signed [VW-1:0]   qy;
      logic signed [AW-1:0]   qang;
      logic [ANGLE_BITS-1:0]  u;
      logic [ANGLE_BITS:0]    v;
      logic [11:0]            col;
      logic [12:0]            rowp;
      logic [11:0]            row;
      logic [23:0]            idx;
   } pipe_type;

   localparam logic [31:0] ATAN_TURN32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // arctangent of 2^-i rounded to ANGLE_BITS bits of a turn
   function automatic logic signed [AW-1:0] atan_step(input int i);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[i % 32]} + (33'd1 << (DROP - 1));
      return AW'(t >> DROP);
   endfunction

   // work of pipeline stage idx (idx >= ST_VEC) on the item of the previous stage
   function automatic pipe_type next_stage(input int idx, input pipe_type p,
                                          input logic [12:0] w, input logic [12:0] h,
                                          input logic [10:0] s);
      pipe_type             q;
      logic signed [12:0]   a;
      logic signed [12:0]   b;
      logic signed [12:0]   sz;
      logic signed [26:0]   acc;
      logic [53:0]          vv;
      logic [1:0]           pair;
      logic [REM_W-1:0]     remn;
      logic [REM_W-1:0]     trial;
      logic signed [VW-1:0] sx;
      logic signed [VW-1:0] sy;
      logic signed [AW-1:0] t;
      logic signed [AW-1:0] lon;
      logic signed [AW:0]   vs;
      logic [28:0]          pu;
      logic [29:0]          pv;
      logic [24:0]          pi;
      int                   k;
      q = p;
      if (idx == ST_VEC) begin
         sz = 13'(s);
         a = 13'({2'b0, p.tx, 1'b1}) - sz;
         b = 13'({2'b0, p.ty, 1'b1}) - sz;
         q.bad = (p.face > FACE_NZ) || (s > 11'(MAX_FACE_SIZE)) ||
                 ({1'b0, p.tx} >= s) || ({1'b0, p.ty} >= s);
         case (p.face)
            FACE_PX: begin q.dx = sz;  q.dy = -b;  q.dz = -a; end
            FACE_NX: begin q.dx = -sz; q.dy = -b;  q.dz = a;  end
            FACE_PY: begin q.dx = a;   q.dy = sz;  q.dz = b;  end
            FACE_NY: begin q.dx = a;   q.dy = -sz; q.dz = -b; end
            FACE_PZ: begin q.dx = a;   q.dy = -b;  q.dz = sz; end
            default: begin q.dx = -a;  q.dy = -b;  q.dz = -sz; end
         endcase
      end else if (idx == ST_PREP) begin
         acc = 27'(p.dx * p.dx) + 27'(p.dz * p.dz);
         q.n = acc[N_W-1:0];
         q.zlon = (p.dx == 13'sd0) && (p.dz == 13'sd0);
         sx = VW'(p.dx) <<< PRE_SHIFT;
         sy = VW'(p.dz) <<< PRE_SHIFT;
         if (p.dx < 0) begin
            q.lx = -sx;
            q.ly = -sy;
            q.lang = AW'(1) <<< (ANGLE_BITS - 1);
         end else begin
            q.lx = sx;
            q.ly = sy;
            q.lang = '0;
         end
         q.rem = '0;
         q.root = '0;
      end else if (idx >= ST_SQRT && idx < ST_LATP) begin
         // one root bit per stage
         k = idx - ST_SQRT;
         vv = {1'b0, p.n, 32'b0};
         pair = vv[2 * (SQRT_STEPS - 1 - k) +: 2];
         remn = {p.rem[REM_W-3:0], pair};
         trial = REM_W'({p.root, 2'b01});
         if (remn >= trial) begin
            q.rem = remn - trial;
            q.root = {p.root[ROOT_W-2:0], 1'b1};
         end else begin
            q.rem = remn;
            q.root = {p.root[ROOT_W-2:0], 1'b0};
         end
         // longitude iterations ride along with the root
         if (k < ANGLE_BITS) begin
            t = atan_step(k);
            sx = p.ly >>> k;
            sy = p.lx >>> k;
            if (!p.ly[VW-1]) begin
               q.lx = p.lx + sx; q.ly = p.ly - sy; q.lang = p.lang + t;
            end else begin
               q.lx = p.lx - sx; q.ly = p.ly + sy; q.lang = p.lang - t;
            end
         end
      end else if (idx == ST_LATP) begin
         q.qx = VW'(p.root);
         q.qy = VW'(p.dy) <<< PRE_SHIFT;
         q.qang = '0;
      end else if (idx >= ST_LAT && idx < ST_UV) begin
         k = idx - ST_LAT;
         t = atan_step(k);
         sx = p.qy >>> k;
         sy = p.qx >>> k;
         if (!p.qy[VW-1]) begin
            q.qx = p.qx + sx; q.qy = p.qy - sy; q.qang = p.qang + t;
         end else begin
            q.qx = p.qx - sx; q.qy = p.qy + sy; q.qang = p.qang - t;
         end
      end else if (idx == ST_UV) begin
         lon = p.zlon ? '0 : p.lang;
         q.u = ANGLE_BITS'(lon + (AW'(1) <<< (ANGLE_BITS - 1)));
         vs = ((AW+1)'(p.qang) <<< 1) + ((AW+1)'(1) <<< (ANGLE_BITS - 1));
         if (vs < 0)
            q.v = '0;
         else if (vs > ((AW+1)'(1) <<< ANGLE_BITS))
            q.v = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
         else
            q.v = vs[ANGLE_BITS:0];
      end else if (idx == ST_MUL) begin
         pu = 29'(p.u) * 29'(w);
         pv = 30'(p.v) * 30'(h);
         q.col = pu[ANGLE_BITS +: 12];
         q.rowp = pv[ANGLE_BITS +: 13];
      end else if (idx == ST_FIX) begin
         // top of the latitude range wraps to the first row
         q.row = (p.rowp == h) ? 12'd0 : p.rowp[11:0];
         if (p.bad) begin
            q.row = '0;
            q.col = '0;
         end
      end else if (idx == ST_IDX) begin
         pi = 25'(p.row) * 25'(w) + 25'(p.col);
         q.idx = p.bad ? 24'd0 : pi[23:0];
      end
      return q;
   endfunction

endpackage

`default_nettype wire

/* design/cte_flow.sv */
// Flow control for the address pipeline: stage valid bits and output skid stage.
// Depends on cte_pkg.
`default_nettype none

module cte_flow (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic                         out_stall,
   output logic                              advance,
   output logic                              skid_load,
   output logic [cte_pkg::NSTAGE-1:0]        vld,
   output logic                              skid_valid
);

   logic [cte_pkg::NSTAGE-1:0] vld_ff;
   logic [cte_pkg::NSTAGE-1:0] vld_in;
   logic                       skid_ff;
   logic                       skid_in;

   // pipeline moves while the skid stage is empty
   assign advance   = !skid_ff;
   assign skid_load = advance && vld_ff[cte_pkg::NSTAGE-1] && out_stall;
   assign vld       = vld_ff;
   assign skid_valid = skid_ff;

   always_comb begin
      vld_in = vld_ff;
      if (advance)
         vld_in = {vld_ff[cte_pkg::NSTAGE-2:0], in_valid};
      skid_in = skid_ff;
      if (skid_load)
         skid_in = 1'b1;
      else if (skid_ff && !out_stall)
         skid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         skid_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         skid_ff <= skid_in;
      end
   end

endmodule

`default_nettype wire

/* design/cube_texel_to_equirect_address.sv */
// Top level of the cube texel to equirectangular address block.
// Depends on cte_pkg and cte_flow.
`default_nettype none

// One result per transfer, one transfer per cycle sustained while rsp_stall is low.
// The pipeline has 51 register stages: one capture stage, vector forming, squaring,
// a 27-stage square root (one root bit per stage, the longitude CORDIC riding along
// in the first 16), latitude setup, 16 latitude CORDIC stages, then angle-to-texel
// scaling, the scale multiply, row wrap and the index multiply. A result is offered
// on rsp_valid when it reaches the last pipeline stage. A skid stage after it holds
// one finished result when rsp_stall is high; the pipeline stalls only while that
// stage is occupied.
// Configuration is written through csr_wr_en, csr_index and csr_wdata and must only
// change while no transfer is in flight.
module cube_texel_to_equirect_address (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cte_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cte_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [12:0]      csr_wdata
);

   logic [12:0] src_width_ff;
   logic [12:0] src_height_ff;
   logic [10:0] face_size_ff;
   logic [12:0] w_sat;
   logic [12:0] h_sat;

   logic                        advance;
   logic                        skid_load;
   logic [cte_pkg::NSTAGE-1:0]  vld;
   logic                        skid_valid;

   cte_pkg::pipe_type stg_ff [cte_pkg::NSTAGE];
   cte_pkg::pipe_type stg_in [cte_pkg::NSTAGE];
   cte_pkg::rsp_type  last_rsp;
   cte_pkg::rsp_type  skid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 13'd2048;
         src_height_ff <= 13'd1024;
         face_size_ff  <= 11'd512;
      end else if (csr_wr_en) begin
         case (csr_index)
            cte_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            cte_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            cte_pkg::CSR_FACE_SIZE:  face_size_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // clamp source size to the largest supported image
   assign w_sat = (src_width_ff > 13'(cte_pkg::MAX_SRC_DIM)) ?
                  13'(cte_pkg::MAX_SRC_DIM) : src_width_ff;
   assign h_sat = (src_height_ff > 13'(cte_pkg::MAX_SRC_DIM)) ?
                  13'(cte_pkg::MAX_SRC_DIM) : src_height_ff;

   cte_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .out_stall  (rsp_stall),
      .advance    (advance),
      .skid_load  (skid_load),
      .vld        (vld),
      .skid_valid (skid_valid)
   );

   assign req_stall = !advance;

   // capture stage: take the request fields, clear the rest
   always_comb begin
      stg_in[0]       = '0;
      stg_in[0].face  = req_data.face;
      stg_in[0].tx    = req_data.tex_x;
      stg_in[0].ty    = req_data.tex_y;
   end

   for (genvar g = 1; g < cte_pkg::NSTAGE; g++) begin : g_stage
      always_comb
         stg_in[g] = cte_pkg::next_stage(g, stg_ff[g-1], w_sat, h_sat, face_size_ff);
   end

   // payload registers advance together; no reset needed
   always_ff @(posedge clock) begin
      if (advance)
         for (int i = 0; i < cte_pkg::NSTAGE; i++)
            stg_ff[i] <= stg_in[i];
   end

   always_comb begin
      last_rsp.src_col   = stg_ff[cte_pkg::NSTAGE-1].col;
      last_rsp.src_row   = stg_ff[cte_pkg::NSTAGE-1].row;
      last_rsp.src_index = stg_ff[cte_pkg::NSTAGE-1].idx;
      last_rsp.bad_coord = stg_ff[cte_pkg::NSTAGE-1].bad;
   end

   // hold the stalled result; the pipeline stalls while it is held
   always_ff @(posedge clock) begin
      if (skid_load)
         skid_ff <= last_rsp;
   end

   assign rsp_valid = skid_valid || vld[cte_pkg::NSTAGE-1];
   assign rsp_data  = skid_valid ? skid_ff : last_rsp;

endmodule

`default_nettype wire
